/* sv/srd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package srd_pkg;

   localparam int DividendWidth = 64;
   localparam int DivisorWidth  = 32;
   localparam int ShiftWidth    = 7;
   localparam int QuoBits       = 31;
   localparam int NumCells      = QuoBits;

   localparam logic [QuoBits-1:0] QuoSat = {QuoBits{1'b1}};

   // Data handed from one division cell to the next.
   typedef struct packed {
      logic                    qneg;
      logic                    ovf;
      logic                    dz;
      logic [QuoBits-1:0]      rem;
      logic [QuoBits-1:0]      low;
      logic [QuoBits-1:0]      quo;
      logic [DivisorWidth-1:0] div;
   } cell_data_type;

endpackage
`default_nettype wire

/* sv/srd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module srd_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire logic signed [srd_pkg::DividendWidth-1:0] dividend,
   input  wire logic signed [srd_pkg::ShiftWidth-1:0]    shift,
   input  wire logic signed [srd_pkg::DivisorWidth-1:0]  divisor,
   output logic                                      out_valid,
   output srd_pkg::cell_data_type                    out_data
);
   import srd_pkg::*;

   logic [DividendWidth-1:0] ux;
   logic [DividendWidth-1:0] ux_sh;
   logic [DivisorWidth-1:0]  uy;
   logic [ShiftWidth-1:0]    rshift;
   logic                     lovf;
   logic [5:0]               lcheck;

   logic                     a_valid_ff, a_valid_in;
   logic [DividendWidth-1:0] a_ux_ff;
   logic [DivisorWidth-1:0]  a_uy_ff;
   logic                     a_qneg_ff, a_ovf_ff, a_dz_ff;

   logic [DividendWidth-1:0] sum;
   logic [DividendWidth-1:0] limit;
   logic                     b_valid_ff;
   cell_data_type            b_data_ff, b_data_in;

   // Stage A: magnitudes and scaling of the dividend.
   always_comb begin
      ux     = dividend[DividendWidth-1] ? (~dividend + 1'b1) : dividend;
      uy     = divisor[DivisorWidth-1] ? (~divisor + 1'b1) : divisor;
      rshift = ~shift + 1'b1;
      lcheck = 6'd63 - shift[5:0];
      lovf   = 1'b0;
      ux_sh  = ux;
      if (!shift[ShiftWidth-1] && shift != '0) begin
         lovf  = (ux >> lcheck) != '0;
         ux_sh = ux << shift[5:0];
      end else if (shift[ShiftWidth-1]) begin
         // A right shift by 64 or more clears the magnitude.
         ux_sh = rshift[ShiftWidth-1] ? '0 : (ux >> rshift[5:0]);
      end
      a_valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_ux_ff   <= ux_sh;
      a_uy_ff   <= uy;
      a_qneg_ff <= dividend[DividendWidth-1] ^ divisor[DivisorWidth-1];
      a_ovf_ff  <= lovf;
      a_dz_ff   <= (divisor == '0);
   end

   // Stage B: rounding term and the quotient range check.
   always_comb begin
      sum   = a_ux_ff + {{(DividendWidth-DivisorWidth+1){1'b0}},
                         a_uy_ff[DivisorWidth-1:1]};
      limit = {1'b0, a_uy_ff, {QuoBits{1'b0}}};
      b_data_in.qneg = a_qneg_ff;
      b_data_in.ovf  = a_ovf_ff | (sum >= limit);
      b_data_in.dz   = a_dz_ff;
      b_data_in.rem  = sum[2*QuoBits-1:QuoBits];
      b_data_in.low  = sum[QuoBits-1:0];
      b_data_in.quo  = '0;
      b_data_in.div  = a_uy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule
`default_nettype wire

/* sv/srd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module srd_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire srd_pkg::cell_data_type in_data,
   output logic                        out_valid,
   output srd_pkg::cell_data_type      out_data
);
   import srd_pkg::*;

   logic [QuoBits:0]   trial;
   logic [QuoBits+1:0] diff;
   logic               take;
   logic               valid_ff;
   cell_data_type      data_ff, data_in;

   // One restoring step: bring down the next dividend bit and try the divisor.
   always_comb begin
      trial = {in_data.rem, in_data.low[QuoBits-1]};
      diff  = {1'b0, trial} - {1'b0, in_data.div};
      take  = !diff[QuoBits+1];
      data_in      = in_data;
      data_in.rem  = take ? diff[QuoBits-1:0] : trial[QuoBits-1:0];
      data_in.low  = {in_data.low[QuoBits-2:0], 1'b0};
      data_in.quo  = {in_data.quo[QuoBits-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* sv/scaled_rounded_divide_64by32_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// From the accepted request to the rsp_strobe cycle a request passes through
// two front stages, one cell per quotient bit and one output register.
// Throughput: one request per cycle; busy is tied low, so nothing stalls the chain.
// Reset clears every valid bit in the pipeline; no result is pending after it.
// The receiver cannot stall: each result is shown for exactly one cycle.
module scaled_rounded_divide_64by32_top (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic signed [srd_pkg::DividendWidth-1:0] req_dividend,
   input  wire logic signed [srd_pkg::ShiftWidth-1:0]    req_shift,
   input  wire logic signed [srd_pkg::DivisorWidth-1:0]  req_divisor,
   output logic                                          rsp_strobe,
   output logic signed [srd_pkg::DivisorWidth-1:0]       rsp_quotient,
   output logic                                          rsp_overflow,
   output logic                                          rsp_divide_by_zero
);
   import srd_pkg::*;

   logic          chain_valid [NumCells+1];
   cell_data_type chain_data  [NumCells+1];

   cell_data_type           last;
   logic [DivisorWidth-1:0] mag;
   logic                    strobe_ff;
   logic [DivisorWidth-1:0] quo_ff, quo_in;
   logic                    ovf_ff, ovf_in;
   logic                    dz_ff, dz_in;

   assign busy = 1'b0;

   srd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .dividend  (req_dividend),
      .shift     (req_shift),
      .divisor   (req_divisor),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      srd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // Saturation, sign and the zero-divisor override.
   always_comb begin
      last   = chain_data[NumCells];
      mag    = {1'b0, (last.ovf ? QuoSat : last.quo)};
      quo_in = last.qneg ? (~mag + 1'b1) : mag;
      ovf_in = last.ovf;
      dz_in  = last.dz;
      if (last.dz) begin
         quo_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain_valid[NumCells];
      end
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      dz_ff  <= dz_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_quotient       = quo_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule
`default_nettype wire

/* verif/scaled_rounded_divide_64by32_top_test.sv */
`timescale 1ns / 1ps
module scaled_rounded_divide_64by32_top_test;
   import srd_pkg::*;

   localparam int RandomItems = 450;
   localparam int DrainCycles = 40;

   localparam logic [DivisorWidth-1:0] SatPos = 32'h7FFF_FFFF;
   localparam logic [DivisorWidth-1:0] SatNeg = 32'h8000_0001;
   localparam logic [DivisorWidth-1:0] MostNegDivisor = 32'h8000_0000;
   localparam logic [DividendWidth-1:0] MostNegDividend = 64'h8000_0000_0000_0000;
   localparam logic [DividendWidth-1:0] MostPosDividend = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ShiftWidth-1:0] ShiftClear = 7'h40;
   localparam logic [ShiftWidth-1:0] ShiftRightMax = 7'h41;
   localparam logic [ShiftWidth-1:0] ShiftLeftMax = 7'h3F;

   typedef struct packed {
      logic [DivisorWidth-1:0] quotient;
      logic                    overflow;
      logic                    divide_by_zero;
   } quotient_result_type;

   typedef struct packed {
      logic [DividendWidth-1:0] dividend;
      logic [ShiftWidth-1:0]    shift;
      logic [DivisorWidth-1:0]  divisor;
      bit                       typed;
      quotient_result_type      want;
   } request_row_type;

   localparam quotient_result_type FromModel = '0;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic signed [DividendWidth-1:0] req_dividend;
   logic signed [ShiftWidth-1:0]    req_shift;
   logic signed [DivisorWidth-1:0]  req_divisor;
   logic                            rsp_strobe;
   logic signed [DivisorWidth-1:0]  rsp_quotient;
   logic                            rsp_overflow;
   logic                            rsp_divide_by_zero;

   quotient_result_type pending_quotients[$];
   int unsigned         failures = 0;

   // Rows with typed set carry a result that can be read straight off the rules.
   request_row_type directed_rows [25] = '{
      '{64'd12345, 7'd0, 32'd0, 1'b1, '{32'd0, 1'b0, 1'b1}},
      '{MostNegDividend, ShiftClear, 32'd0, 1'b1, '{32'd0, 1'b0, 1'b1}},
      '{64'hFFFF_FFFF_FFFF_FFFF, ShiftLeftMax, 32'd0, 1'b1, '{32'd0, 1'b0, 1'b1}},
      '{64'd0, 7'd0, 32'd1, 1'b1, '{32'd0, 1'b0, 1'b0}},
      '{64'd100, 7'd0, 32'd7, 1'b0, FromModel},
      '{64'hFFFF_FFFF_FFFF_FF9C, 7'd0, 32'd7, 1'b0, FromModel},
      '{64'd100, 7'd0, 32'hFFFF_FFF9, 1'b0, FromModel},
      '{64'hFFFF_FFFF_FFFF_FF9C, 7'd0, 32'hFFFF_FFF9, 1'b0, FromModel},
      '{MostPosDividend, 7'd0, 32'd1, 1'b1, '{SatPos, 1'b1, 1'b0}},
      '{MostNegDividend, 7'd0, 32'd1, 1'b1, '{SatNeg, 1'b1, 1'b0}},
      '{MostNegDividend, 7'd0, MostNegDivisor, 1'b1, '{SatPos, 1'b1, 1'b0}},
      '{64'd1, ShiftLeftMax, 32'd1, 1'b1, '{SatPos, 1'b1, 1'b0}},
      '{64'd1, 7'd62, 32'd3, 1'b0, FromModel},
      '{MostPosDividend, ShiftRightMax, 32'd1, 1'b1, '{32'd0, 1'b0, 1'b0}},
      '{MostNegDividend, ShiftRightMax, 32'd1, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, ShiftClear, 32'd5, 1'b1, '{32'd0, 1'b0, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 32'd3, 1'b0, FromModel},
      '{64'h7FFF_FFFF, 7'd0, 32'd1, 1'b1, '{SatPos, 1'b0, 1'b0}},
      '{64'h8000_0000, 7'd0, 32'd1, 1'b1, '{SatPos, 1'b1, 1'b0}},
      '{64'hFFFF_FFFE, 7'd0, 32'd2, 1'b0, FromModel},
      '{64'hFFFF_FFFF, 7'd0, 32'd2, 1'b0, FromModel},
      '{64'h3FFF_FFFF_FFFF_FFFF, 7'd1, 32'h7FFF_FFFF, 1'b0, FromModel},
      '{64'h4000_0000_0000_0000, 7'd1, 32'h7FFF_FFFF, 1'b0, FromModel},
      '{64'd5, 7'd0, 32'hFFFF_FFFF, 1'b0, FromModel},
      '{64'h0000_0100_0000_0000, 7'd3, MostNegDivisor, 1'b0, FromModel}
   };

   scaled_rounded_divide_64by32_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_dividend       (req_dividend),
      .req_shift          (req_shift),
      .req_divisor        (req_divisor),
      .rsp_strobe         (rsp_strobe),
      .rsp_quotient       (rsp_quotient),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic quotient_result_type predict_quotient(
      input logic [DividendWidth-1:0] dividend,
      input logic [ShiftWidth-1:0]    shift,
      input logic [DivisorWidth-1:0]  divisor
   );
      logic [63:0]         mag_num;
      logic [63:0]         mag_div;
      logic [31:0]         mag_quo;
      logic                negative;
      logic                saturated;
      int                  amount;
      quotient_result_type result;
      result = '0;
      if (divisor == '0) begin
         result.divide_by_zero = 1'b1;
         return result;
      end
      negative = dividend[63] ^ divisor[31];
      mag_num = dividend[63] ? 64'd0 - dividend : dividend;
      mag_div = {32'd0, divisor[31] ? 32'd0 - divisor : divisor};
      amount = int'($signed(shift));
      saturated = 1'b0;
      if (amount > 0) begin
         // The left shift may not push any magnitude bit into the sign position.
         if ((mag_num >> (63 - amount)) != 0)
            saturated = 1'b1;
         else
            mag_num = mag_num << amount;
      end else if (amount < 0) begin
         mag_num = (-amount >= 64) ? 64'd0 : mag_num >> (-amount);
      end
      if (!saturated) begin
         mag_num = mag_num + (mag_div >> 1);
         if (mag_num >= (mag_div << 31))
            saturated = 1'b1;
      end
      mag_quo = saturated ? SatPos : 32'(mag_num / mag_div);
      result.quotient = negative ? 32'd0 - mag_quo : mag_quo;
      result.overflow = saturated;
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: MISMATCH %s", $time, what);
      failures++;
   endtask

   always @(posedge clock) begin
      quotient_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_quotients.size() == 0) begin
            report_mismatch($sformatf("result with no request pending, quotient %0d",
                                      rsp_quotient));
         end else begin
            want = pending_quotients.pop_front();
            if (rsp_quotient !== want.quotient)
               report_mismatch($sformatf("quotient %0d, expected %0d",
                                         rsp_quotient, $signed(want.quotient)));
            if (rsp_overflow !== want.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_overflow, want.overflow));
            if (rsp_divide_by_zero !== want.divide_by_zero)
               report_mismatch($sformatf("divide_by_zero %b, expected %b",
                                         rsp_divide_by_zero, want.divide_by_zero));
         end
      end
   end

   task automatic send_request(
      input logic [DividendWidth-1:0] dividend,
      input logic [ShiftWidth-1:0]    shift,
      input logic [DivisorWidth-1:0]  divisor,
      input bit                       typed,
      input quotient_result_type      typed_result
   );
      @(negedge clock);
      start <= 1'b1;
      req_dividend <= dividend;
      req_shift <= shift;
      req_divisor <= divisor;
      do @(posedge clock); while (busy);
      pending_quotients.push_back(typed ? typed_result
                                        : predict_quotient(dividend, shift, divisor));
   endtask

   // Holds start low for a pause as long as the cycles argument; junk on the data ports
   // must be ignored while no request is offered.
   task automatic pause_requests(input int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         req_dividend <= {$urandom, $urandom};
         req_divisor <= $urandom;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_quotients();
      @(negedge clock);
      start <= 1'b0;
      while (pending_quotients.size() != 0) @(posedge clock);
   endtask

   function automatic int unsigned gap_cycles(input bit bursting);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (bursting || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic random_request();
      longint unsigned          mag_num;
      longint unsigned          mag_div;
      longint unsigned          target;
      logic [DividendWidth-1:0] dividend;
      logic [DivisorWidth-1:0]  divisor;
      logic [ShiftWidth-1:0]    shift;
      int                       amount;
      mag_div = longint'({$urandom}) >> $urandom_range(1, 31);
      if (mag_div == 0) mag_div = 1;
      if ($urandom_range(0, 15) == 0) mag_div = 64'h8000_0000;
      divisor = $urandom_range(0, 1) ? 32'(64'd0 - mag_div) : 32'(mag_div);
      shift = '0;
      dividend = '0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // Build a dividend whose quotient lands inside the 31-bit range,
            // pre-scaled against the shift the block will apply.
            target = longint'({$urandom}) >> $urandom_range(1, 32);
            mag_num = target * mag_div + (longint'({$urandom}) % mag_div);
            amount = int'($urandom_range(0, 16)) - 8;
            if (amount > 0) begin
               mag_num = mag_num >> amount;
            end else if (amount < 0) begin
               if ((mag_num >> (63 + amount)) == 0)
                  mag_num = mag_num << -amount;
               else
                  amount = 0;
            end
            shift = 7'(amount);
            dividend = $urandom_range(0, 1) ? 64'd0 - mag_num : mag_num;
         end
         4, 5: begin
            dividend = 64'(longint'(int'($urandom_range(0, 2097152)) - 1048576));
            divisor = 32'(int'($urandom_range(0, 2000)) - 1000);
            shift = 7'(int'($urandom_range(0, 24)) - 4);
         end
         6, 7: begin
            dividend = {$urandom, $urandom};
            divisor = $urandom;
            shift = 7'($urandom);
         end
         8: begin
            // Straddle the point where the rounded quotient reaches 2^31.
            mag_num = (mag_div << 31) - (mag_div >> 1)
                      + 64'(longint'(int'($urandom_range(0, 3)) - 2));
            dividend = $urandom_range(0, 1) ? 64'd0 - mag_num : mag_num;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: divisor = 32'd0;
               1: divisor = 32'd1;
               2: divisor = 32'hFFFF_FFFF;
               3: divisor = MostNegDivisor;
               default: divisor = 32'h7FFF_FFFF;
            endcase
            dividend = {$urandom, $urandom} >> $urandom_range(0, 63);
            if ($urandom_range(0, 1)) dividend = 64'd0 - dividend;
            shift = 7'($urandom);
         end
      endcase
      send_request(dividend, shift, divisor, 1'b0, FromModel);
   endtask

   initial begin
      bit bursting;
      bursting = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_dividend = '0;
      req_shift = '0;
      req_divisor = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].dividend, directed_rows[i].shift,
                      directed_rows[i].divisor, directed_rows[i].typed,
                      directed_rows[i].want);
         pause_requests(gap_cycles(1'b0));
      end
      wait_for_quotients();

      for (int n = 0; n < RandomItems; n++) begin
         if (n % 32 == 0) bursting = ($urandom_range(0, 3) == 0);
         if (n == RandomItems / 2) wait_for_quotients();
         random_request();
         pause_requests(gap_cycles(bursting));
      end

      wait_for_quotients();
      repeat (DrainCycles) @(posedge clock);
      if (pending_quotients.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_quotients.size()));
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t ns: timeout", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
